// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge out of reset
`define ASSERT_CLK(label, clk_s, rst_n_s, prop, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) else $error(msg);

// whenever trig holds, cons must hold in the next cycle
`define ASSERT_NEXT(label, clk_s, rst_n_s, trig, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (trig) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_CLK(label, clk_s, rst_n_s, prop, msg)
`define ASSERT_NEXT(label, clk_s, rst_n_s, trig, cons, msg)

`endif

`endif

// File: rtl/core/sge_pkg.sv
// ----------------------------------------------------------------------------
// Glyph emitter package
// Screen size, register indexes, sequencer states and the glyph column ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package sge_pkg;

	localparam int SCREEN_WIDTH  = 240;
	localparam int SCREEN_HEIGHT = 240;

	localparam int GLYPH_COLS  = 5;
	localparam int GLYPH_ROWS  = 8;
	localparam int GLYPH_COUNT = 12;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FG_COLOR    = 2'd0,
		CFG_BG_COLOR    = 2'd1,
		CFG_GLYPH_SCALE = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH
	} sge_state_t;

	typedef struct packed {
		logic [7:0]  win_x0;
		logic [7:0]  win_y0;
		logic [7:0]  win_x1;
		logic [7:0]  win_y1;
		logic [15:0] pixel_color;
		logic        last;
	} win_t;

	// one glyph per entry, column 0 in the low byte, row 0 in bit 0 of a column
	localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
		40'h00_00_00_00_00,  // space
		40'h3E_45_49_51_3E,  // 0
		40'h00_40_7F_42_00,  // 1
		40'h46_49_51_61_42,  // 2
		40'h31_4B_45_41_21,  // 3
		40'h10_7F_12_14_18,  // 4
		40'h39_45_45_45_27,  // 5
		40'h30_49_49_4A_3C,  // 6
		40'h03_05_09_71_01,  // 7
		40'h36_49_49_49_36,  // 8
		40'h1E_29_49_49_06,  // 9
		40'h00_00_36_36_00   // colon
	};

	function automatic logic [7:0] glyph_column(input logic [3:0] sel, input logic [2:0] col);
		logic [39:0] g;
		g = (sel < 4'(GLYPH_COUNT)) ? GLYPH_ROM[sel] : 40'h0;
		return (col < 3'(GLYPH_COLS)) ? g[{col, 3'b000} +: 8] : 8'h00;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/sge_req_if.sv
// ----------------------------------------------------------------------------
// Character request channel
// Valid/ready channel carrying a character code and a signed glyph origin.
// ----------------------------------------------------------------------------
`default_nettype none

interface sge_req_if;
	logic               valid;
	logic               ready;
	logic [7:0]         char_code;
	logic signed [15:0] origin_x;
	logic signed [15:0] origin_y;

	modport source (output valid, output char_code, output origin_x, output origin_y,
		input ready);
	modport sink (input valid, input char_code, input origin_x, input origin_y,
		output ready);
endinterface

`default_nettype wire

// File: rtl/core/sge_win_if.sv
// ----------------------------------------------------------------------------
// Window result channel
// Valid/ready channel carrying one clipped rectangle and its fill color.
// ----------------------------------------------------------------------------
`default_nettype none

interface sge_win_if;
	logic        valid;
	logic        ready;
	logic [7:0]  win_x0;
	logic [7:0]  win_y0;
	logic [7:0]  win_x1;
	logic [7:0]  win_y1;
	logic [15:0] pixel_color;
	logic        last;

	modport source (output valid, output win_x0, output win_y0, output win_x1,
		output win_y1, output pixel_color, output last, input ready);
	modport sink (input valid, input win_x0, input win_y0, input win_x1,
		input win_y1, input pixel_color, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/scaled_glyph_rect_emitter.sv
// The sequencer visits one glyph dot per cycle unless stalled, and takes no new
// character until it is idle again after the flush. A stalled output holds the
// dot walk only when a second window is found behind it.
// Unsupported codes are dropped in the accept cycle.
// Reset (arst_n low): colors 0xFFFF/0x0000, scale 1, sequencer idle, no window.
// ----------------------------------------------------------------------------
// Scaled glyph rectangle emitter
// Expands a character into per-dot clipped windows, one dot per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module scaled_glyph_rect_emitter (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [sge_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sge_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	sge_req_if.sink                              req,
	sge_win_if.source                            rsp
);
	import sge_pkg::*;

	typedef struct packed {
		logic       ok;
		logic [7:0] lo;
		logic [7:0] hi;
	} axis_t;

	// one axis of the clip: [max(p,0), min(p+s,lim)-1], empty or offscreen drops
	function automatic axis_t clip_axis(input logic [15:0] p, input logic [7:0] s,
		input logic signed [17:0] lim);
		logic signed [17:0] pe;
		logic signed [17:0] e;
		logic signed [17:0] lo;
		logic signed [17:0] hi;
		axis_t r;
		pe = {{2{p[15]}}, p};
		e  = pe + $signed({10'b0, s});
		if (e > lim) e = lim;
		lo = (pe < 0) ? 18'sd0 : pe;
		hi = e - 18'sd1;
		r.ok = (pe < lim) && (e > lo);
		r.lo = lo[7:0];
		r.hi = hi[7:0];
		return r;
	endfunction

	localparam logic signed [17:0] SCR_W = 18'(SCREEN_WIDTH);
	localparam logic signed [17:0] SCR_H = 18'(SCREEN_HEIGHT);

	sge_state_t  state_q, state_nx;

	logic [15:0] fg_q, bg_q;
	logic [7:0]  scale_q;

	logic [3:0]  sel_q;
	logic [2:0]  col_q;
	logic [2:0]  row_q;
	logic [15:0] px_q, py_q, oy_q;

	win_t        pend_q, out_q;
	logic        pend_valid_q, out_valid_q;

	logic        code_ok;
	logic [3:0]  code_sel;
	logic [7:0]  col_bits;
	logic        dot_set, draw;
	logic [15:0] color;
	axis_t       cx, cy;
	logic        hit, out_busy, stall, step, last_dot, flush_push, accept;
	win_t        new_win;

	always_comb begin
		code_ok  = 1'b1;
		code_sel = 4'd0;
		case (req.char_code) inside
			8'h20:          code_sel = 4'd0;
			[8'h30:8'h39]:  code_sel = 4'(req.char_code - 8'h2F);
			8'h3A:          code_sel = 4'd11;
			default:        code_ok  = 1'b0;
		endcase
	end

	// per-dot evaluation
	always_comb begin
		col_bits = glyph_column(sel_q, col_q);
		dot_set  = col_bits[row_q];
		draw     = dot_set || (bg_q != fg_q);
		color    = dot_set ? fg_q : bg_q;
		cx       = clip_axis(px_q, scale_q, SCR_W);
		cy       = clip_axis(py_q, scale_q, SCR_H);
		new_win  = '{win_x0: cx.lo, win_y0: cy.lo, win_x1: cx.hi, win_y1: cy.hi,
			pixel_color: color, last: 1'b0};
	end

	// handshake and sequencer outputs
	always_comb begin
		req.ready  = (state_q == ST_IDLE);
		accept     = req.valid && req.ready;
		out_busy   = out_valid_q && !rsp.ready;
		hit        = (state_q == ST_RUN) && draw && cx.ok && cy.ok;
		stall      = hit && pend_valid_q && out_busy;
		step       = (state_q == ST_RUN) && !stall;
		last_dot   = (col_q == 3'(GLYPH_COLS - 1)) && (row_q == 3'(GLYPH_ROWS - 1));
		flush_push = (state_q == ST_FLUSH) && pend_valid_q && !out_busy;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:  if (accept && code_ok) state_nx = ST_RUN;
			ST_RUN:   if (step && last_dot) state_nx = ST_FLUSH;
			ST_FLUSH: if (!pend_valid_q || !out_busy) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fg_q         <= 16'hFFFF;
			bg_q         <= 16'h0000;
			scale_q      <= 8'd1;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;

			if (cfg_we) begin
				case (cfg_index)
					CFG_FG_COLOR:    fg_q    <= cfg_wdata;
					CFG_BG_COLOR:    bg_q    <= cfg_wdata;
					CFG_GLYPH_SCALE: scale_q <= cfg_wdata[7:0];
					default:         ;
				endcase
			end

			// a new window pushes the held one out; the held one is last at flush
			if (hit && pend_valid_q && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (flush_push) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			if (step && hit) begin
				pend_valid_q <= 1'b1;
			end else if (flush_push) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (hit && pend_valid_q && !out_busy) begin
			out_q <= pend_q;
		end else if (flush_push) begin
			// last is the low bit of the window
			out_q <= {pend_q[$bits(win_t)-1:1], 1'b1};
		end

		if (step && hit) pend_q <= new_win;

		if (accept) begin
			sel_q <= code_sel;
			col_q <= 3'd0;
			row_q <= 3'd0;
			px_q  <= req.origin_x;
			py_q  <= req.origin_y;
			oy_q  <= req.origin_y;
		end else if (step) begin
			if (row_q == 3'(GLYPH_ROWS - 1)) begin
				row_q <= 3'd0;
				col_q <= col_q + 3'd1;
				py_q  <= oy_q;
				px_q  <= px_q + {8'b0, scale_q};
			end else begin
				row_q <= row_q + 3'd1;
				py_q  <= py_q + {8'b0, scale_q};
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.win_x0      = out_q.win_x0;
	assign rsp.win_y0      = out_q.win_y0;
	assign rsp.win_x1      = out_q.win_x1;
	assign rsp.win_y1      = out_q.win_y1;
	assign rsp.pixel_color = out_q.pixel_color;
	assign rsp.last        = out_q.last;

	`ASSERT_CLK(a_idle_no_pend, clk, arst_n, (state_q != ST_IDLE) || !pend_valid_q, "window left held while idle")
	`ASSERT_CLK(a_col_range, clk, arst_n, (state_q != ST_RUN) || (col_q < 3'(GLYPH_COLS)), "dot column past glyph")
	`ASSERT_NEXT(a_flush_last, clk, arst_n, flush_push, rsp.valid && rsp.last, "flushed window not marked last")
	`ASSERT_CLK(a_win_order, clk, arst_n, !rsp.valid || ((rsp.win_x0 <= rsp.win_x1) && (rsp.win_y0 <= rsp.win_y1)), "window corners out of order")

endmodule

`default_nettype wire
